@@ src/graph_reachability_engine_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Graph reachability engine assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRAPH_REACHABILITY_ENGINE_UNIT_ASSERT_SVH
`define GRAPH_REACHABILITY_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GRE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("graph reachability engine: same-cycle check failed");

// Next-cycle implication.
`define GRE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("graph reachability engine: next-cycle check failed");

`endif

@@ src/gre_pkg.sv @@
// ----------------------------------------------------------------------------
// Graph reachability engine package
// Field widths, operation and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package gre_pkg;

    localparam int VERTEX_W = 5;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 6;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_MAX_DEGREE   = 16;

    localparam logic [CFG_W-1:0] NUM_VERTICES_RESET = 6'd32;

    localparam logic [FUNC_W-1:0] FUNC_CONNECT    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DISCONNECT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY      = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

endpackage

@@ src/graph_reachability_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Graph reachability engine
// Directed graph kept as per-vertex edge lists; connect, disconnect and
// depth-first reachability queries run under one small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive func, src_vertex and dst_vertex with start high;
//   the word is taken at a clock edge where busy is low. busy stays high
//   until the result is out.
//   Result channel: done pulses for one cycle with reached and status. The
//   receiver cannot stall; it must take the word in that cycle.
//   Config channel: cfg_data is written to num_vertices on cfg_valid and
//   cfg_ready; cfg_ready is low while busy is high.
// Sequence, accept edge to done cycle:
//   connect, out-of-range and unknown: settled in the check state.
//   disconnect: reads the last slot, then compares slots from slot 0 on.
//   query: pushes the source, then pops vertices and reads each popped
//   vertex's edges, pushing unvisited ones, until dst is popped or the stack
//   is empty. Edge reads come one a cycle from the single edge memory port.
//   busy is low in the done cycle, so a new command may be taken at the
//   edge that ends it.
// Reset: graph empty, num_vertices = 32, block idle. Edge and stack memories
//   are not cleared; only entries below a degree or stack count are read.
// ----------------------------------------------------------------------------
module graph_reachability_engine_unit #(
    parameter int MAX_VERTICES = gre_pkg::DEF_MAX_VERTICES,
    parameter int MAX_DEGREE   = gre_pkg::DEF_MAX_DEGREE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gre_pkg::FUNC_W-1:0]    func,
    input  logic [gre_pkg::VERTEX_W-1:0]  src_vertex,
    input  logic [gre_pkg::VERTEX_W-1:0]  dst_vertex,
    output logic                          done,
    output logic                          reached,
    output logic [gre_pkg::STATUS_W-1:0]  status,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gre_pkg::CFG_W-1:0]     cfg_data
);

    import gre_pkg::*;

    localparam int EDGE_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int ADDR_W     = $clog2(EDGE_DEPTH);
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int VIDX_W     = $clog2(MAX_VERTICES);
    localparam int SP_W       = $clog2(MAX_VERTICES + 1);
    localparam int NV_W       = $clog2(MAX_VERTICES + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_DLAST = 7'b0000100,
        S_DCMP  = 7'b0001000,
        S_POP   = 7'b0010000,
        S_POPW  = 7'b0100000,
        S_SCAN  = 7'b1000000
    } state_t;

    function automatic logic [ADDR_W-1:0] edge_addr(
        input logic [VERTEX_W-1:0] v,
        input logic [DEG_W-1:0]    s
    );
        edge_addr = ADDR_W'(ADDR_W'(v) * ADDR_W'(MAX_DEGREE) + ADDR_W'(s));
    endfunction

    state_t                 state_reg, state_next;
    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [VERTEX_W-1:0]    src_reg, src_next;
    logic [VERTEX_W-1:0]    dst_reg, dst_next;
    logic [VERTEX_W-1:0]    cur_v_reg, cur_v_next;
    logic [DEG_W-1:0]       cur_deg_reg, cur_deg_next;
    logic [DEG_W-1:0]       cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [VERTEX_W-1:0]    last_reg, last_next;
    logic [SP_W-1:0]        sp_reg, sp_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic                   done_reg, done_next;
    logic                   reached_reg, reached_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [CFG_W-1:0]       num_vertices_reg;

    logic [DEG_W-1:0]       out_degree_reg [MAX_VERTICES];
    logic                   deg_we;
    logic [VIDX_W-1:0]      deg_waddr;
    logic [DEG_W-1:0]       deg_wdata;
    logic [VERTEX_W-1:0]    deg_rvertex;
    logic [DEG_W-1:0]       cur_deg;

    logic [VERTEX_W-1:0]    edge_mem [EDGE_DEPTH];
    logic                   edge_we, edge_re;
    logic [ADDR_W-1:0]      edge_waddr, edge_raddr;
    logic [VERTEX_W-1:0]    edge_wdata;
    logic [VERTEX_W-1:0]    edge_rd_reg;

    logic [VERTEX_W-1:0]    stack_mem [MAX_VERTICES];
    logic                   stack_we, stack_re;
    logic [VIDX_W-1:0]      stack_waddr, stack_raddr;
    logic [VERTEX_W-1:0]    stack_wdata;
    logic [VERTEX_W-1:0]    stack_rd_reg;

    logic [NV_W-1:0]        nv;
    logic                   func_known;
    logic                   push_ok;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign reached   = reached_reg;
    assign status    = status_reg;
    assign cfg_ready = !busy;

    always_comb
    begin
        if (int'(num_vertices_reg) > MAX_VERTICES)
        begin
            nv = NV_W'(MAX_VERTICES);
        end
        else
        begin
            nv = NV_W'(num_vertices_reg);
        end
    end

    assign func_known = (func_reg == FUNC_CONNECT) || (func_reg == FUNC_DISCONNECT) ||
                        (func_reg == FUNC_QUERY);
    assign deg_rvertex = (state_reg == S_POPW) ? stack_rd_reg : src_reg;
    assign cur_deg     = out_degree_reg[VIDX_W'(deg_rvertex)];
    assign push_ok     = (int'(edge_rd_reg) < int'(nv)) &&
                         !visited_reg[VIDX_W'(edge_rd_reg)] &&
                         (sp_reg < SP_W'(MAX_VERTICES));

    always_comb
    begin
        state_next   = state_reg;
        func_next    = func_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        cur_v_next   = cur_v_reg;
        cur_deg_next = cur_deg_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        last_next    = last_reg;
        sp_next      = sp_reg;
        visited_next = visited_reg;
        done_next    = 1'b0;
        reached_next = reached_reg;
        status_next  = status_reg;
        deg_we       = 1'b0;
        deg_waddr    = VIDX_W'(src_reg);
        deg_wdata    = cur_deg;
        edge_we      = 1'b0;
        edge_waddr   = edge_addr(src_reg, cur_deg);
        edge_wdata   = dst_reg;
        edge_re      = 1'b0;
        edge_raddr   = edge_addr(src_reg, cnt_reg);
        stack_we     = 1'b0;
        stack_waddr  = sp_reg[VIDX_W-1:0];
        stack_wdata  = edge_rd_reg;
        stack_re     = 1'b0;
        stack_raddr  = VIDX_W'(sp_reg - SP_W'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    src_next   = src_vertex;
                    dst_next   = dst_vertex;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (!func_known)
                begin
                    done_next    = 1'b1;
                    reached_next = 1'b0;
                    status_next  = STATUS_OK;
                    state_next   = S_IDLE;
                end
                else if ((int'(src_reg) >= int'(nv)) || (int'(dst_reg) >= int'(nv)))
                begin
                    done_next    = 1'b1;
                    reached_next = 1'b0;
                    status_next  = STATUS_RANGE;
                    state_next   = S_IDLE;
                end
                else if (func_reg == FUNC_CONNECT)
                begin
                    done_next    = 1'b1;
                    reached_next = 1'b0;
                    state_next   = S_IDLE;
                    if (cur_deg >= DEG_W'(MAX_DEGREE))
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        edge_we     = 1'b1;
                        deg_we      = 1'b1;
                        deg_wdata   = cur_deg + DEG_W'(1);
                    end
                end
                else if (func_reg == FUNC_DISCONNECT)
                begin
                    if (cur_deg == '0)
                    begin
                        done_next    = 1'b1;
                        reached_next = 1'b0;
                        status_next  = STATUS_OK;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        cur_deg_next = cur_deg;
                        edge_re      = 1'b1;
                        edge_raddr   = edge_addr(src_reg, cur_deg - DEG_W'(1));
                        state_next   = S_DLAST;
                    end
                end
                else
                begin
                    if (src_reg == dst_reg)
                    begin
                        done_next    = 1'b1;
                        reached_next = 1'b1;
                        status_next  = STATUS_OK;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        visited_next = '0;
                        visited_next[VIDX_W'(src_reg)] = 1'b1;
                        stack_we     = 1'b1;
                        stack_waddr  = '0;
                        stack_wdata  = src_reg;
                        sp_next      = SP_W'(1);
                        state_next   = S_POP;
                    end
                end
            end
            S_DLAST:
            begin
                last_next  = edge_rd_reg;
                cnt_next   = '0;
                edge_re    = 1'b1;
                edge_raddr = edge_addr(src_reg, '0);
                state_next = S_DCMP;
            end
            S_DCMP:
            begin
                if (edge_rd_reg == dst_reg)
                begin
                    edge_we      = 1'b1;
                    edge_waddr   = edge_addr(src_reg, cnt_reg);
                    edge_wdata   = last_reg;
                    deg_we       = 1'b1;
                    deg_wdata    = cur_deg_reg - DEG_W'(1);
                    done_next    = 1'b1;
                    reached_next = 1'b0;
                    status_next  = STATUS_OK;
                    state_next   = S_IDLE;
                end
                else if (cnt_reg == cur_deg_reg - DEG_W'(1))
                begin
                    done_next    = 1'b1;
                    reached_next = 1'b0;
                    status_next  = STATUS_OK;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + DEG_W'(1);
                    edge_re    = 1'b1;
                    edge_raddr = edge_addr(src_reg, cnt_reg + DEG_W'(1));
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    done_next    = 1'b1;
                    reached_next = 1'b0;
                    status_next  = STATUS_OK;
                    state_next   = S_IDLE;
                end
                else
                begin
                    sp_next    = sp_reg - SP_W'(1);
                    stack_re   = 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                if (stack_rd_reg == dst_reg)
                begin
                    sp_next      = '0;
                    done_next    = 1'b1;
                    reached_next = 1'b1;
                    status_next  = STATUS_OK;
                    state_next   = S_IDLE;
                end
                else if (cur_deg == '0)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    cur_v_next = stack_rd_reg;
                    cnt_next   = cur_deg;
                    pend_next  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (pend_reg && push_ok)
                begin
                    visited_next[VIDX_W'(edge_rd_reg)] = 1'b1;
                    stack_we = 1'b1;
                    sp_next  = sp_reg + SP_W'(1);
                end
                if (cnt_reg != '0)
                begin
                    edge_re    = 1'b1;
                    edge_raddr = edge_addr(cur_v_reg, cnt_reg - DEG_W'(1));
                    cnt_next   = cnt_reg - DEG_W'(1);
                    pend_next  = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_POP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sp_reg           <= '0;
            pend_reg         <= 1'b0;
            visited_reg      <= '0;
            done_reg         <= 1'b0;
            num_vertices_reg <= NUM_VERTICES_RESET;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                out_degree_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            sp_reg      <= sp_next;
            pend_reg    <= pend_next;
            visited_reg <= visited_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                num_vertices_reg <= cfg_data;
            end
            if (deg_we)
            begin
                out_degree_reg[deg_waddr] <= deg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        cur_v_reg   <= cur_v_next;
        cur_deg_reg <= cur_deg_next;
        cnt_reg     <= cnt_next;
        last_reg    <= last_next;
        reached_reg <= reached_next;
        status_reg  <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        if (edge_re)
        begin
            edge_rd_reg <= edge_mem[edge_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[stack_raddr];
        end
    end

`include "graph_reachability_engine_unit_assert.svh"

    `GRE_ASSERT_NXT(a_done_single, done_reg, !done_reg)
    `GRE_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `GRE_ASSERT_IMP(a_idle_with_done, $fell(busy), done_reg)
    `GRE_ASSERT_IMP(a_reached_ok, done_reg && reached_reg, status_reg == STATUS_OK)
    `GRE_ASSERT_IMP(a_stack_bound, state_reg == S_SCAN, $countones(visited_reg) >= int'(sp_reg))

endmodule

@@ tb/sv/tb_graph_reachability_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Graph reachability engine testbench
// Drives connect, disconnect and reachability commands into the engine under
// several vertex counts and sender idle patterns. A bench shadow graph predicts
// results unless a table row pins one, and each done word is checked in order.
// ----------------------------------------------------------------------------
module tb_graph_reachability_engine_unit;

    import gre_pkg::*;

    localparam int MAX_V          = DEF_MAX_VERTICES;
    localparam int MAX_DEG        = DEF_MAX_DEGREE;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 20;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASES         = 9;
    localparam int PHASE_WORDS    = 122;
    localparam int TABLE_LEN      = 29;

    localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

    typedef struct packed {
        logic                reached;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef struct packed {
        bit                  is_cfg;
        logic [CFG_W-1:0]    cfg_value;
        logic [FUNC_W-1:0]   f;
        logic [VERTEX_W-1:0] s;
        logic [VERTEX_W-1:0] d;
        bit                  pinned;
        logic                want_reached;
        logic [STATUS_W-1:0] want_status;
    } table_row_t;

    localparam table_row_t OPENING_TABLE [TABLE_LEN] = '{
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd0,  5'd0,  1'b1, 1'b1, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd31, 5'd0,  1'b1, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_CONNECT,    5'd0,  5'd31, 1'b1, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_CONNECT,    5'd31, 5'd0,  1'b1, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd0,  5'd31, 1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_CONNECT,    5'd0,  5'd31, 1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_DISCONNECT, 5'd0,  5'd31, 1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd0,  5'd31, 1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_DISCONNECT, 5'd5,  5'd6,  1'b1, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_UNKNOWN,    5'd31, 5'd31, 1'b1, 1'b0, STATUS_OK},
        '{1'b1, 6'd63, FUNC_CONNECT,    5'd0,  5'd0,  1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd31, 5'd0,  1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_CONNECT,    5'd31, 5'd31, 1'b0, 1'b0, STATUS_OK},
        '{1'b1, 6'd16, FUNC_CONNECT,    5'd0,  5'd0,  1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd0,  5'd15, 1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_CONNECT,    5'd16, 5'd0,  1'b1, 1'b0, STATUS_RANGE},
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd0,  5'd16, 1'b1, 1'b0, STATUS_RANGE},
        '{1'b0, 6'd0,  FUNC_DISCONNECT, 5'd15, 5'd31, 1'b1, 1'b0, STATUS_RANGE},
        '{1'b1, 6'd0,  FUNC_CONNECT,    5'd0,  5'd0,  1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd0,  5'd0,  1'b1, 1'b0, STATUS_RANGE},
        '{1'b0, 6'd0,  FUNC_CONNECT,    5'd0,  5'd0,  1'b1, 1'b0, STATUS_RANGE},
        '{1'b0, 6'd0,  FUNC_UNKNOWN,    5'd0,  5'd0,  1'b1, 1'b0, STATUS_OK},
        '{1'b1, 6'd1,  FUNC_CONNECT,    5'd0,  5'd0,  1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_CONNECT,    5'd0,  5'd0,  1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd0,  5'd0,  1'b1, 1'b1, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_CONNECT,    5'd0,  5'd1,  1'b1, 1'b0, STATUS_RANGE},
        '{1'b1, 6'd32, FUNC_CONNECT,    5'd0,  5'd0,  1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd31, 5'd31, 1'b0, 1'b0, STATUS_OK},
        '{1'b0, 6'd0,  FUNC_QUERY,      5'd0,  5'd31, 1'b0, 1'b0, STATUS_OK}
    };

    localparam logic [CFG_W-1:0] PHASE_VERTICES [PHASES] = '{
        6'd32, 6'd2, 6'd8, 6'd1, 6'd63, 6'd5, 6'd16, 6'd4, 6'd32
    };

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic                busy;
    logic [FUNC_W-1:0]   func       = FUNC_CONNECT;
    logic [VERTEX_W-1:0] src_vertex = '0;
    logic [VERTEX_W-1:0] dst_vertex = '0;
    logic                done;
    logic                reached;
    logic [STATUS_W-1:0] status;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [CFG_W-1:0]    cfg_data   = '0;

    // Shadow graph
    logic [VERTEX_W-1:0] adjacency [MAX_V][MAX_DEG];
    logic [VERTEX_W-1:0] fanout [MAX_V] = '{default: '0};
    logic [CFG_W-1:0]    vertex_limit   = NUM_VERTICES_RESET;

    result_t             pending_results [$];
    bit                  pin_on         = 1'b0;
    result_t             pinned_result  = '0;
    int                  failures       = 0;
    int                  quiet_cycles   = 0;
    int                  idle_pct       = 0;
    logic [CFG_W-1:0]    drive_limit    = NUM_VERTICES_RESET;

    graph_reachability_engine_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .src_vertex (src_vertex),
        .dst_vertex (dst_vertex),
        .done       (done),
        .reached    (reached),
        .status     (status),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic result_t apply_command(input logic [FUNC_W-1:0] f,
                                              input logic [VERTEX_W-1:0] s,
                                              input logic [VERTEX_W-1:0] d);
        result_t             r;
        int                  limit;
        int                  deg;
        int                  i;
        int                  depth;
        int                  v;
        int                  w;
        bit                  found;
        logic [MAX_V-1:0]    seen;
        logic [VERTEX_W-1:0] stack [MAX_V];
        r.reached = 1'b0;
        r.status  = STATUS_OK;
        limit     = (vertex_limit > MAX_V) ? MAX_V : int'(vertex_limit);
        deg       = int'(fanout[s]);
        if (f == FUNC_UNKNOWN) begin
            r.status = STATUS_OK;
        end
        else if (s >= limit || d >= limit) begin
            r.status = STATUS_RANGE;
        end
        else if (f == FUNC_CONNECT) begin
            if (deg >= MAX_DEG) begin
                r.status = STATUS_FULL;
            end
            else begin
                adjacency[s][deg] = d;
                fanout[s]         = VERTEX_W'(deg + 1);
            end
        end
        else if (f == FUNC_DISCONNECT) begin
            found = 1'b0;
            for (i = 0; i < deg && !found; i++) begin
                if (adjacency[s][i] == d) begin
                    adjacency[s][i] = adjacency[s][deg-1];
                    fanout[s]       = VERTEX_W'(deg - 1);
                    found           = 1'b1;
                end
            end
        end
        else begin
            // Mark on push, so the stack stays within the vertex count.
            seen     = '0;
            seen[s]  = 1'b1;
            stack[0] = s;
            depth    = 1;
            while (depth > 0 && !r.reached) begin
                depth--;
                v = int'(stack[depth]);
                if (v == d) begin
                    r.reached = 1'b1;
                end
                else begin
                    for (i = int'(fanout[v]); i > 0; i--) begin
                        w = int'(adjacency[v][i-1]);
                        if (w < limit && !seen[w] && depth < MAX_V) begin
                            seen[w]      = 1'b1;
                            stack[depth] = VERTEX_W'(w);
                            depth++;
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk) begin : check_results
        result_t want_word;
        result_t got_word;
        if (rst_n) begin
            got_word = '{reached, status};
            if (done) begin
                if (pending_results.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected word: reached=%0d status=%0d",
                                 got_word.reached, got_word.status);
                end
                else begin
                    want_word = pending_results.pop_front();
                    if (got_word !== want_word) begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("mismatch: expected reached=%0d status=%0d,",
                                     want_word.reached, want_word.status,
                                     " got reached=%0d status=%0d",
                                     got_word.reached, got_word.status);
                    end
                end
            end
            if (start && !busy) begin
                want_word = apply_command(func, src_vertex, dst_vertex);
                if (pin_on)
                    want_word = pinned_result;
                pending_results = {pending_results, want_word};
            end
            if (cfg_valid && cfg_ready)
                vertex_limit = cfg_data;
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [FUNC_W-1:0] f,
                             input logic [VERTEX_W-1:0] s,
                             input logic [VERTEX_W-1:0] d,
                             input bit pin,
                             input result_t want);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        func          <= f;
        src_vertex    <= s;
        dst_vertex    <= d;
        pin_on        <= pin;
        pinned_result <= want;
        do @(posedge clk); while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (busy || pending_results.size() != 0);
    endtask

    task automatic write_num_vertices(input logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        drive_limit  = value;
    endtask

    initial begin
        int                  row;
        int                  phase;
        int                  n;
        int                  pick;
        int                  lim;
        logic [FUNC_W-1:0]   f;
        logic [VERTEX_W-1:0] s;
        logic [VERTEX_W-1:0] d;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        for (row = 0; row < TABLE_LEN; row++) begin
            if (OPENING_TABLE[row].is_cfg)
                write_num_vertices(OPENING_TABLE[row].cfg_value);
            else
                send_word(OPENING_TABLE[row].f, OPENING_TABLE[row].s,
                          OPENING_TABLE[row].d, OPENING_TABLE[row].pinned,
                          '{OPENING_TABLE[row].want_reached,
                            OPENING_TABLE[row].want_status});
        end

        for (phase = 0; phase < PHASES; phase++) begin
            idle_pct = (phase < 3) ? 20 : (phase < 6) ? 71 : 0;
            if (phase == 7)
                write_num_vertices(CFG_W'($urandom_range(63, 1)));
            else
                write_num_vertices(PHASE_VERTICES[phase]);
            lim = (drive_limit > MAX_V) ? MAX_V : int'(drive_limit);
            for (n = 0; n < PHASE_WORDS; n++) begin
                pick = $urandom_range(99);
                f = (pick < 40) ? FUNC_CONNECT :
                    (pick < 60) ? FUNC_DISCONNECT :
                    (pick < 95) ? FUNC_QUERY : FUNC_UNKNOWN;
                if (lim == 0 || $urandom_range(99) < 8) begin
                    s = VERTEX_W'($urandom);
                    d = VERTEX_W'($urandom);
                end
                else begin
                    s = VERTEX_W'($urandom_range(lim - 1));
                    d = VERTEX_W'($urandom_range(lim - 1));
                end
                // Aim most removals at a stored edge.
                if (f == FUNC_DISCONNECT && fanout[s] != 0 && $urandom_range(3) != 0)
                    d = adjacency[s][$urandom_range(int'(fanout[s]) - 1)];
                send_word(f, s, d, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/gre_pkg.sv
src/graph_reachability_engine_unit.sv
tb/sv/tb_graph_reachability_engine_unit.sv
